[rtl/core/bts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Holds the sequencer states, the interface structs of the shared units and
// the two colour decode tables built at elaboration.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Field widths
    localparam int DIM_W   = 9;   // texture dimension register
    localparam int IDX_W   = 18;  // signed integer texel coordinate
    localparam int FRAC_W  = 16;  // coordinate fraction
    localparam int ADDR_W  = 16;  // texel store address
    localparam int TEXEL_W = 32;  // RGBA8 texel
    localparam int CH_W    = 16;  // Q1.15 channel

    // Shared multiply-add unit: res = a * b + c
    localparam int MAC_A_W = 24;
    localparam int MAC_B_W = 17;
    localparam int MAC_C_W = 34;
    localparam int MAC_R_W = 42;

    localparam logic [CH_W-1:0] ONE_Q15 = 16'd32768;

    // Operation codes carried in tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_REPEAT = 2'd2;
    localparam logic [1:0] CFG_SRGB   = 2'd3;

    // Blend phases within one channel
    localparam logic [1:0] PH_TOP  = 2'd0;
    localparam logic [1:0] PH_BOT  = 2'd1;
    localparam logic [1:0] PH_VERT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_U,
        ST_MUL_V,
        ST_CAP_V,
        ST_WRAP,
        ST_MOD_X,
        ST_MOD_Y,
        ST_F_ADDR,
        ST_F_READ,
        ST_F_DATA,
        ST_B_ISSUE,
        ST_B_CAP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [MAC_C_W-1:0] c;
    } mac_op_t;

    typedef struct packed {
        logic                    start;
        logic signed [IDX_W-1:0] value;
        logic [DIM_W-1:0]        modulus;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] rem;
    } mod_rsp_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0] wdata;
    } mem_req_t;

    typedef logic [255:0][CH_W-1:0] rom_t;

    localparam logic [63:0] Q30 = 64'd1073741824;

    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // sRGB to linear, Q1.15: linear segment, then the 2.4 power through a
    // fifth root search in Q30.
    function automatic rom_t build_srgb_rom();
        rom_t        rom;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < 256; i++)
        begin
            if (i <= 10)
            begin
                rom[i] = 16'((64'(i) * 64'd3276800 + 64'd164730) / 64'd329460);
            end
            else
            begin
                t  = ((64'(1000 * i + 14025) << 30) + 64'd134512) / 64'd269025;
                t2 = (t * t + 64'd536870912) >> 30;
                lo = 64'd0;
                hi = Q30;
                for (int s = 0; s < 32; s++)
                begin
                    if (lo < hi)
                    begin
                        mid = lo + ((hi - lo + 64'd1) >> 1);
                        if (pow5_q30(mid) <= t2)
                        begin
                            lo = mid;
                        end
                        else
                        begin
                            hi = mid - 64'd1;
                        end
                    end
                end
                rom[i] = 16'((((t2 * lo) >> 30) + 64'd16384) >> 15);
            end
        end
        return rom;
    endfunction

    // byte / 255 in Q1.15, rounded as the integer division of the spec
    function automatic rom_t build_lin_rom();
        rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = 16'((64'(i) * 64'd32768 + 64'd127) / 64'd255);
        end
        return rom;
    endfunction

    localparam rom_t SRGB_ROM = build_srgb_rom();
    localparam rom_t LIN_ROM  = build_lin_rom();

endpackage
`default_nettype wire

[rtl/core/bts_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bts_mac: shared multiply-add unit
// Registers a * b + c; the result appears in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module bts_mac
(
    input  wire logic                                clk,
    input  wire bts_pkg::mac_op_t                    op,
    output logic signed [bts_pkg::MAC_R_W-1:0]       res
);

    logic signed [bts_pkg::MAC_A_W-1:0]                   a;
    logic signed [bts_pkg::MAC_B_W-1:0]                   b;
    logic signed [bts_pkg::MAC_C_W-1:0]                   c;
    logic signed [bts_pkg::MAC_A_W+bts_pkg::MAC_B_W-1:0]  prod;
    logic signed [bts_pkg::MAC_R_W-1:0]                   res_reg;
    logic signed [bts_pkg::MAC_R_W-1:0]                   res_next;

    assign a = op.a;
    assign b = op.b;
    assign c = op.c;

    always_comb
    begin
        prod     = a * b;
        res_next = $signed({prod[40], prod}) + $signed({{8{c[33]}}, c});
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

[rtl/core/bts_modu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bts_modu: iterative modulo unit
// Restoring remainder, one quotient bit a cycle; floor modulo of a signed
// coordinate by the texture dimension.
// ----------------------------------------------------------------------------
module bts_modu
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bts_pkg::mod_req_t req,
    output bts_pkg::mod_rsp_t      rsp
);

    localparam int CNT_W = $clog2(bts_pkg::IDX_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [bts_pkg::IDX_W-1:0]   mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [bts_pkg::DIM_W-1:0]   n_reg, n_next;
    logic [bts_pkg::DIM_W-1:0]   r_reg, r_next;
    logic [bts_pkg::DIM_W-1:0]   rem_reg, rem_next;
    logic [bts_pkg::DIM_W:0]     trial;
    logic [bts_pkg::DIM_W:0]     diff;
    logic [bts_pkg::DIM_W-1:0]   r_step;
    logic [bts_pkg::IDX_W-1:0]   value_u;

    always_comb
    begin
        value_u   = req.value;
        trial     = {r_reg, mag_reg[bts_pkg::IDX_W-1]};
        diff      = trial - {1'b0, n_reg};
        r_step    = (trial >= {1'b0, n_reg}) ? diff[bts_pkg::DIM_W-1:0]
                                             : trial[bts_pkg::DIM_W-1:0];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            r_next   = r_step;
            mag_next = {mag_reg[bts_pkg::IDX_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // floor modulo: fold a negative remainder back into range
                rem_next  = (neg_reg && (r_step != '0)) ? (n_reg - r_step) : r_step;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(bts_pkg::IDX_W);
            neg_next  = value_u[bts_pkg::IDX_W-1];
            mag_next  = value_u[bts_pkg::IDX_W-1]
                      ? (~value_u + {{(bts_pkg::IDX_W-1){1'b0}}, 1'b1}) : value_u;
            n_next    = req.modulus;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

[rtl/core/bts_texmem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bts_texmem: texel store
// Single-port 64K x 32 memory with registered read data.
// ----------------------------------------------------------------------------
module bts_texmem
(
    input  wire logic                           clk,
    input  wire bts_pkg::mem_req_t              req,
    output logic [bts_pkg::TEXEL_W-1:0]         rdata
);

    logic [bts_pkg::TEXEL_W-1:0] mem [1 << bts_pkg::ADDR_W];
    logic [bts_pkg::TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/core/bilinear_texture_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_texture_sampler: RGBA8 texture unit with bilinear filtering
// Stores texels in a 64K-entry memory and returns filtered Q1.15 RGBA for
// sample transactions, every product on one shared multiply-add unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tuser operation, s_tdata texel
//          |           |                    | write fields and u,v
//  m_*     | out       | m_tvalid/m_tready  | m_tdata filtered RGBA, Q1.15
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_wdata
//
//  In a sample, two coordinate products, four address products and twelve
//  blends go through the one multiply-add unit, the modulo unit spends
//  18 steps per axis in repeat mode, and the four texels are read one at
//  a time from the single-port store.
//  s_tready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next transaction is accepted.
//  Reset clears the configuration (srgb on) and control; the store is not
//  cleared and reads of unwritten texels return arbitrary data.
//
module bilinear_texture_sampler
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample / write stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] texel_index, [23:16] texel_red, [31:24] texel_green,
    // [39:32] texel_blue, [47:40] texel_alpha, [71:48] coord_u,
    // [95:72] coord_v
    input  wire logic [95:0] s_tdata,
    // [0] operation
    input  wire logic        s_tuser,
    // filtered result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue, [63:48] out_alpha
    output logic [63:0]      m_tdata,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_wdata
);

    bts_pkg::state_t state_reg, state_next;

    // configuration
    logic [8:0]         width_reg, width_next;
    logic [8:0]         height_reg, height_next;
    logic               repeat_reg, repeat_next;
    logic               srgb_reg, srgb_next;

    // sample working set
    logic signed [23:0] u_reg, u_next;
    logic signed [23:0] v_reg, v_next;
    logic signed [17:0] ix_reg, ix_next;
    logic signed [17:0] iy_reg, iy_next;
    logic [15:0]        tx_reg, tx_next;
    logic [15:0]        ty_reg, ty_next;
    logic [8:0]         x0_reg, x0_next;
    logic [8:0]         x1_reg, x1_next;
    logic [8:0]         y0_reg, y0_next;
    logic [8:0]         y1_reg, y1_next;
    logic [1:0]         fk_reg, fk_next;
    logic [1:0]         ph_reg, ph_next;
    logic [1:0]         ch_reg, ch_next;
    logic [63:0]        ta_reg, ta_next;
    logic [63:0]        tb_reg, tb_next;
    logic [63:0]        tc_reg, tc_next;
    logic [63:0]        td_reg, td_next;
    logic [15:0]        top_reg, top_next;
    logic [15:0]        bot_reg, bot_next;
    logic [63:0]        res_reg, res_next;

    // output register
    logic [63:0]        out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic [8:0]         w_eff;
    logic [8:0]         h_eff;
    logic [8:0]         fx;
    logic [8:0]         fy;
    logic [15:0]        p_sel;
    logic [15:0]        q_sel;
    logic [15:0]        t_sel;
    logic signed [16:0] diff;
    logic [15:0]        blend_val;

    bts_pkg::mac_op_t                    mac_op;
    logic signed [bts_pkg::MAC_R_W-1:0]  mac_res;
    bts_pkg::mod_req_t                   mod_req;
    bts_pkg::mod_rsp_t                   mod_rsp;
    bts_pkg::mem_req_t                   mem_req;
    logic [31:0]                         mem_rdata;

    bts_mac u_mac
    (
        .clk (clk),
        .op  (mac_op),
        .res (mac_res)
    );

    bts_modu u_modu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    bts_texmem u_texmem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Clamp a signed coordinate to [0, n-1].
    function automatic logic [8:0] clamp_edge(input logic signed [18:0] val,
                                              input logic [8:0] n);
        logic [8:0] n_m1;
        n_m1 = n - 9'd1;
        if (val < 19'sd0)
        begin
            return 9'd0;
        end
        else if (val > $signed({10'd0, n_m1}))
        begin
            return n_m1;
        end
        return val[8:0];
    endfunction

    // Right-hand neighbour of an already wrapped coordinate.
    function automatic logic [8:0] wrap_next(input logic [8:0] rem, input logic [8:0] n);
        logic [8:0] sum;
        sum = rem + 9'd1;
        return (sum == n) ? 9'd0 : sum;
    endfunction

    // Decode one texel into four Q1.15 channels, red lowest.
    function automatic logic [63:0] decode_texel(input logic [31:0] t, input logic srgb);
        logic [63:0] d;
        for (int k = 0; k < 3; k++)
        begin
            d[16*k +: 16] = srgb ? bts_pkg::SRGB_ROM[t[8*k +: 8]]
                                 : bts_pkg::LIN_ROM[t[8*k +: 8]];
        end
        d[63:48] = bts_pkg::LIN_ROM[t[31:24]];
        return d;
    endfunction

    // Saturate oversize dimensions to the parameter limits.
    assign w_eff = ({23'd0, width_reg} > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_reg;
    assign h_eff = ({23'd0, height_reg} > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_reg;

    // Neighbour order: a (x0,y0), b (x1,y0), c (x0,y1), d (x1,y1).
    assign fx = fk_reg[0] ? x1_reg : x0_reg;
    assign fy = fk_reg[1] ? y1_reg : y0_reg;

    assign blend_val = mac_res[31:16];

    always_comb
    begin
        // blend operands for the current phase; the channel in work always
        // sits in the low 16 bits of the texel registers
        case (ph_reg)
            bts_pkg::PH_TOP:
            begin
                p_sel = ta_reg[15:0];
                q_sel = tb_reg[15:0];
                t_sel = tx_reg;
            end
            bts_pkg::PH_BOT:
            begin
                p_sel = tc_reg[15:0];
                q_sel = td_reg[15:0];
                t_sel = tx_reg;
            end
            default:
            begin
                p_sel = top_reg;
                q_sel = bot_reg;
                t_sel = ty_reg;
            end
        endcase
        diff = $signed({1'b0, q_sel}) - $signed({1'b0, p_sel});
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        repeat_next    = repeat_reg;
        srgb_next      = srgb_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        fk_next        = fk_reg;
        ph_next        = ph_reg;
        ch_next        = ch_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        tc_next        = tc_reg;
        td_next        = td_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        // drop the held result once the sink takes it
        out_valid_next = out_valid_reg && !m_tready;

        s_tready       = 1'b0;

        mac_op.a       = '0;
        mac_op.b       = '0;
        mac_op.c       = '0;

        mod_req.start   = 1'b0;
        mod_req.value   = ix_reg;
        mod_req.modulus = w_eff;

        mem_req.we     = 1'b0;
        mem_req.addr   = mac_res[15:0];
        mem_req.wdata  = s_tdata[47:16];

        if (cfg_we)
        begin
            case (cfg_index)
                bts_pkg::CFG_WIDTH:  width_next  = cfg_wdata;
                bts_pkg::CFG_HEIGHT: height_next = cfg_wdata;
                bts_pkg::CFG_REPEAT: repeat_next = cfg_wdata[0];
                bts_pkg::CFG_SRGB:   srgb_next   = cfg_wdata[0];
                default:             ;
            endcase
        end

        case (state_reg)
            bts_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == bts_pkg::OP_WRITE)
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = s_tdata[15:0];
                    end
                    else if ((width_reg == 9'd0) || (height_reg == 9'd0))
                    begin
                        res_next   = {4{bts_pkg::ONE_Q15}};
                        state_next = bts_pkg::ST_OUT;
                    end
                    else
                    begin
                        u_next     = $signed(s_tdata[71:48]);
                        v_next     = $signed(s_tdata[95:72]);
                        state_next = bts_pkg::ST_MUL_U;
                    end
                end
            end

            // x = u*W - 0.5, y = v*H - 0.5 in Q.16
            bts_pkg::ST_MUL_U:
            begin
                mac_op.a   = u_reg;
                mac_op.b   = $signed({8'd0, w_eff});
                mac_op.c   = -34'sd32768;
                state_next = bts_pkg::ST_MUL_V;
            end

            bts_pkg::ST_MUL_V:
            begin
                mac_op.a   = v_reg;
                mac_op.b   = $signed({8'd0, h_eff});
                mac_op.c   = -34'sd32768;
                ix_next    = $signed(mac_res[33:16]);
                tx_next    = mac_res[15:0];
                state_next = bts_pkg::ST_CAP_V;
            end

            bts_pkg::ST_CAP_V:
            begin
                iy_next    = $signed(mac_res[33:16]);
                ty_next    = mac_res[15:0];
                state_next = bts_pkg::ST_WRAP;
            end

            bts_pkg::ST_WRAP:
            begin
                if (repeat_reg)
                begin
                    mod_req.start = 1'b1;
                    state_next    = bts_pkg::ST_MOD_X;
                end
                else
                begin
                    x0_next    = clamp_edge($signed({ix_reg[17], ix_reg}), w_eff);
                    x1_next    = clamp_edge($signed({ix_reg[17], ix_reg}) + 19'sd1, w_eff);
                    y0_next    = clamp_edge($signed({iy_reg[17], iy_reg}), h_eff);
                    y1_next    = clamp_edge($signed({iy_reg[17], iy_reg}) + 19'sd1, h_eff);
                    fk_next    = 2'd0;
                    state_next = bts_pkg::ST_F_ADDR;
                end
            end

            // wrap x, then launch y as soon as x is back
            bts_pkg::ST_MOD_X:
            begin
                mod_req.value   = iy_reg;
                mod_req.modulus = h_eff;
                if (mod_rsp.done)
                begin
                    x0_next       = mod_rsp.rem;
                    x1_next       = wrap_next(mod_rsp.rem, w_eff);
                    mod_req.start = 1'b1;
                    state_next    = bts_pkg::ST_MOD_Y;
                end
            end

            bts_pkg::ST_MOD_Y:
            begin
                if (mod_rsp.done)
                begin
                    y0_next    = mod_rsp.rem;
                    y1_next    = wrap_next(mod_rsp.rem, h_eff);
                    fk_next    = 2'd0;
                    state_next = bts_pkg::ST_F_ADDR;
                end
            end

            // address = y*W + x, low 16 bits
            bts_pkg::ST_F_ADDR:
            begin
                mac_op.a   = $signed({15'd0, fy});
                mac_op.b   = $signed({8'd0, w_eff});
                mac_op.c   = $signed({25'd0, fx});
                state_next = bts_pkg::ST_F_READ;
            end

            bts_pkg::ST_F_READ:
            begin
                state_next = bts_pkg::ST_F_DATA;
            end

            // advance the texel chain so texel a lands in ta after four reads
            bts_pkg::ST_F_DATA:
            begin
                ta_next = tb_reg;
                tb_next = tc_reg;
                tc_next = td_reg;
                td_next = decode_texel(mem_rdata, srgb_reg);
                fk_next = fk_reg + 2'd1;
                if (fk_reg == 2'd3)
                begin
                    ph_next    = bts_pkg::PH_TOP;
                    ch_next    = 2'd0;
                    state_next = bts_pkg::ST_B_ISSUE;
                end
                else
                begin
                    state_next = bts_pkg::ST_F_ADDR;
                end
            end

            // blend = (p*65536 + 32768 + (q-p)*t) >> 16
            bts_pkg::ST_B_ISSUE:
            begin
                mac_op.a   = $signed({{7{diff[16]}}, diff});
                mac_op.b   = $signed({1'b0, t_sel});
                mac_op.c   = $signed({2'b00, p_sel, 16'h8000});
                state_next = bts_pkg::ST_B_CAP;
            end

            bts_pkg::ST_B_CAP:
            begin
                case (ph_reg)
                    bts_pkg::PH_TOP:
                    begin
                        top_next   = blend_val;
                        ph_next    = bts_pkg::PH_BOT;
                        state_next = bts_pkg::ST_B_ISSUE;
                    end
                    bts_pkg::PH_BOT:
                    begin
                        bot_next   = blend_val;
                        ph_next    = bts_pkg::PH_VERT;
                        state_next = bts_pkg::ST_B_ISSUE;
                    end
                    default:
                    begin
                        // shift the finished channel in and the next one down
                        res_next = {blend_val, res_reg[63:16]};
                        ta_next  = {16'd0, ta_reg[63:16]};
                        tb_next  = {16'd0, tb_reg[63:16]};
                        tc_next  = {16'd0, tc_reg[63:16]};
                        td_next  = {16'd0, td_reg[63:16]};
                        ph_next  = bts_pkg::PH_TOP;
                        ch_next  = ch_reg + 2'd1;
                        if (ch_reg == 2'd3)
                        begin
                            state_next = bts_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = bts_pkg::ST_B_ISSUE;
                        end
                    end
                endcase
            end

            // hold until the output register is free
            bts_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = bts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bts_pkg::ST_IDLE;
            width_reg     <= 9'd0;
            height_reg    <= 9'd0;
            repeat_reg    <= 1'b0;
            srgb_reg      <= 1'b1;
            fk_reg        <= 2'd0;
            ph_reg        <= bts_pkg::PH_TOP;
            ch_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            repeat_reg    <= repeat_next;
            srgb_reg      <= srgb_next;
            fk_reg        <= fk_next;
            ph_reg        <= ph_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        ix_reg       <= ix_next;
        iy_reg       <= iy_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        ta_reg       <= ta_next;
        tb_reg       <= tb_next;
        tc_reg       <= tc_next;
        td_reg       <= td_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bilinear texture sampler
// Loads texels through the input stream, samples them under a range of
// texture sizes, wrap and decode modes, and compares every filtered RGBA
// result with an in-bench prediction computed at the moment each
// transaction is accepted.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TEX_MAX_W     = 256;
    localparam int TEX_MAX_H     = 256;
    // Longest sample is a repeat-mode one; pad it.
    localparam int SETTLE_CYCLES = 100;
    // Output hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 600;
    // Textures up to this many texels are loaded in full; larger ones get
    // a 16 x 16 block at the origin.
    localparam int FULL_FILL_MAX = 4096;
    localparam int PRINT_LIMIT   = 50;

    typedef logic [3:0][bts_pkg::CH_W-1:0] rgba_t;   // [0] red ... [3] alpha

    typedef struct packed {
        logic               op;
        logic [15:0]        index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [23:0] u;
        logic signed [23:0] v;
    } texture_item_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic        s_tuser   = bts_pkg::OP_WRITE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = bts_pkg::CFG_WIDTH;
    logic [8:0]  cfg_wdata = '0;

    always #10 clk = ~clk;

    bilinear_texture_sampler
    #(
        .MAX_WIDTH  (TEX_MAX_W),
        .MAX_HEIGHT (TEX_MAX_H)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [15:0] index, [23:16] red, [31:24] green, [39:32] blue,
        // [47:40] alpha, [71:48] u, [95:72] v
        .s_tdata   (s_tdata),
        // [0] operation
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [15:0] red, [31:16] green, [47:32] blue, [63:48] alpha
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow registers, shadow texel store and the
    // sRGB decode table built once at time zero
    // ------------------------------------------------------------------
    logic [8:0]  tex_w   = 9'd0;
    logic [8:0]  tex_h   = 9'd0;
    bit          wrap_on = 1'b0;
    bit          srgb_on = 1'b1;

    logic [31:0] texel_mem   [65536];
    bit          texel_valid [65536];   // entries written so far
    int unsigned srgb_lut    [256];

    rgba_t       expected_colors [$];    // filtered colors still to come
    int          mismatch_count = 0;
    int          result_count   = 0;

    bit          idle_on   = 1'b1;       // random idling on both sides
    int          hold_req  = 0;          // bump to request an output hold-off
    int          hold_seen = 0;
    int          hold_left = 0;

    // ------------------------------------------------------------------
    // Decode table: linear segment for the low codes, then the 2.4 power
    // as the square of ((c + 0.055) / 1.055) times its fifth root, all Q30
    // ------------------------------------------------------------------
    function automatic longint unsigned fifth_power(longint unsigned r);
        longint unsigned sq;
        longint unsigned quad;
        sq   = (r * r) >> 30;
        quad = (sq * sq) >> 30;
        return (quad * r) >> 30;
    endfunction

    function automatic int unsigned srgb_entry(int i);
        longint unsigned base;
        longint unsigned base_sq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (i <= 10)
        begin
            return int'((64'(i) * 64'd3276800 + 64'd164730) / 64'd329460);
        end
        base    = ((64'(1000 * i + 14025) << 30) + 64'd134512) / 64'd269025;
        base_sq = (base * base + 64'd536870912) >> 30;
        lo      = 64'd0;
        hi      = 64'd1073741824;
        // largest Q30 root whose fifth power stays at or below base_sq
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (fifth_power(mid) <= base_sq)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return int'((((base_sq * lo) >> 30) + 64'd16384) >> 15);
    endfunction

    // ------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------
    function automatic int eff_dim(logic [8:0] d, int limit);
        return (int'(d) > limit) ? limit : int'(d);
    endfunction

    // Scale a Q8.16 coordinate by the texture size, shift back by half a
    // texel and split into an integer part (floor) and a 16-bit fraction.
    function automatic void split_coord(input logic signed [23:0] coord, input int n,
                                        output longint ip, output logic [15:0] fp);
        longint pos;
        pos = longint'(coord) * longint'(n) - 64'sd32768;
        ip  = pos >>> 16;
        fp  = pos[15:0];
    endfunction

    function automatic longint wrap_index(longint i, longint n);
        longint r;
        if (wrap_on)
        begin
            r = i % n;
            return (r < 0) ? r + n : r;
        end
        if (i < 0)
            return 0;
        if (i > n - 1)
            return n - 1;
        return i;
    endfunction

    function automatic int texel_addr(longint x, longint y, int w, int h);
        longint xi;
        longint yi;
        xi = wrap_index(x, w);
        yi = wrap_index(y, h);
        return int'((yi * w + xi) & 64'd65535);
    endfunction

    function automatic int unsigned channel_level(logic [7:0] b, bit colour);
        if (colour && srgb_on)
            return srgb_lut[b];
        return (int'(b) * 32768 + 127) / 255;
    endfunction

    function automatic int unsigned blend(int unsigned a, int unsigned b, logic [15:0] t);
        longint unsigned m;
        m = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t);
        return int'((m + 64'd32768) >> 16);
    endfunction

    function automatic rgba_t filter_sample(logic signed [23:0] u, logic signed [23:0] v);
        rgba_t       res;
        int          w;
        int          h;
        longint      ix;
        longint      iy;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [31:0] corner [4];
        int unsigned lvl    [4];
        int unsigned top;
        int unsigned bottom;
        if (tex_w == 9'd0 || tex_h == 9'd0)
        begin
            for (int k = 0; k < 4; k++)
                res[k] = bts_pkg::ONE_Q15;
        end
        else
        begin
            w = eff_dim(tex_w, TEX_MAX_W);
            h = eff_dim(tex_h, TEX_MAX_H);
            split_coord(u, w, ix, fx);
            split_coord(v, h, iy, fy);
            // corners: 0 (x, y), 1 (x+1, y), 2 (x, y+1), 3 (x+1, y+1)
            for (int j = 0; j < 4; j++)
                corner[j] = texel_mem[texel_addr(ix + j % 2, iy + j / 2, w, h)];
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 4; j++)
                    lvl[j] = channel_level(corner[j][8*k +: 8], k < 3);
                top    = blend(lvl[0], lvl[1], fx);
                bottom = blend(lvl[2], lvl[3], fx);
                res[k] = 16'(blend(top, bottom, fy));
            end
        end
        return res;
    endfunction

    // True when all four neighbours of (u, v) have been written, so the
    // sample never touches an undefined store entry.
    function automatic bit coords_defined(logic signed [23:0] u, logic signed [23:0] v);
        int          w;
        int          h;
        longint      ix;
        longint      iy;
        logic [15:0] fx;
        logic [15:0] fy;
        if (tex_w == 9'd0 || tex_h == 9'd0)
            return 1'b1;
        w = eff_dim(tex_w, TEX_MAX_W);
        h = eff_dim(tex_h, TEX_MAX_H);
        split_coord(u, w, ix, fx);
        split_coord(v, h, iy, fy);
        for (int j = 0; j < 4; j++)
            if (!texel_valid[texel_addr(ix + j % 2, iy + j / 2, w, h)])
                return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_texel();
        return {random_byte(), random_byte(), random_byte(), random_byte()};
    endfunction

    // Fields that the operation ignores are filled at random anyway.
    function automatic texture_item_t write_item(logic [15:0] idx, logic [31:0] rgba);
        texture_item_t item;
        item.op    = bts_pkg::OP_WRITE;
        item.index = idx;
        item.red   = rgba[7:0];
        item.green = rgba[15:8];
        item.blue  = rgba[23:16];
        item.alpha = rgba[31:24];
        item.u     = 24'($urandom);
        item.v     = 24'($urandom);
        return item;
    endfunction

    function automatic texture_item_t sample_item(logic signed [23:0] u, logic signed [23:0] v);
        texture_item_t item;
        item       = write_item(16'($urandom), $urandom);
        item.op    = bts_pkg::OP_SAMPLE;
        item.u     = u;
        item.v     = v;
        return item;
    endfunction

    function automatic logic signed [23:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2: return 24'($urandom);
            3, 4, 5: return 24'($urandom_range(0, 65535));
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       return 24'h800000;
                    1:       return 24'h7FFFFF;
                    2:       return 24'h000000;
                    3:       return 24'h010000;
                    4:       return 24'hFFFFFF;
                    default: return 24'h000001;
                endcase
            end
            // just around 0.0 and 1.0
            7: return 24'(($urandom_range(0, 1) ? 65536 : 0) + int'($urandom_range(0, 1200)) - 600);
            // any tile, close to the origin inside it
            default: return {8'($urandom), 16'($urandom_range(128, 3967))};
        endcase
    endfunction

    // Draw coordinates until all four neighbours are defined; fall back to
    // the middle of the origin block, which is always loaded.
    task automatic pick_coords(output logic signed [23:0] u, output logic signed [23:0] v);
        int tries;
        tries = 0;
        u     = random_coord();
        v     = random_coord();
        while (!coords_defined(u, v) && tries < 40)
        begin
            u = random_coord();
            v = random_coord();
            tries++;
        end
        if (!coords_defined(u, v))
        begin
            u = 24'sd2048;
            v = 24'sd2048;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: offer one transaction, idle at random first, and update
    // the prediction at the edge where it is accepted. Called and returns
    // right after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(input texture_item_t item);
        while (idle_on && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= item.op;
        s_tdata  <= {item.v, item.u, item.alpha, item.blue, item.green, item.red, item.index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (item.op == bts_pkg::OP_WRITE)
        begin
            texel_mem[item.index]   = {item.alpha, item.blue, item.green, item.red};
            texel_valid[item.index] = 1'b1;
        end
        else
        begin
            expected_colors.insert(expected_colors.size(), filter_sample(item.u, item.v));
        end
    endtask

    // Drop valid, wait out every outstanding result, then let a trailing
    // write or sample finish before anything is reconfigured.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write all four registers; the mode flags carry random upper bits,
    // which the block must ignore.
    task automatic apply_settings(input logic [8:0] width, input logic [8:0] height,
                                  input bit wrap, input bit srgb);
        logic [1:0] index [4];
        logic [8:0] value [4];
        index = '{bts_pkg::CFG_WIDTH, bts_pkg::CFG_HEIGHT, bts_pkg::CFG_REPEAT,
                  bts_pkg::CFG_SRGB};
        value = '{width, height, {8'($urandom), wrap}, {8'($urandom), srgb}};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= index[k];
            cfg_wdata <= value[k];
            @(posedge clk);
            case (index[k])
                bts_pkg::CFG_WIDTH:  tex_w   = value[k];
                bts_pkg::CFG_HEIGHT: tex_h   = value[k];
                bts_pkg::CFG_REPEAT: wrap_on = value[k][0];
                bts_pkg::CFG_SRGB:   srgb_on = value[k][0];
                default:             ;
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Load every texel a sample could reach; only the origin block of the
    // largest textures.
    task automatic fill_texture();
        int w;
        int h;
        int rows;
        int cols;
        int addr;
        w    = eff_dim(tex_w, TEX_MAX_W);
        h    = eff_dim(tex_h, TEX_MAX_H);
        rows = h;
        cols = w;
        if (w * h > FULL_FILL_MAX)
        begin
            rows = (h < 16) ? h : 16;
            cols = (w < 16) ? w : 16;
        end
        for (int y = 0; y < rows; y++)
            for (int x = 0; x < cols; x++)
            begin
                addr = y * w + x;
                if (!texel_valid[addr])
                    send_item(write_item(16'(addr), random_texel()));
            end
    endtask

    // One setting: reconfigure, load, then a random mix of texel updates
    // (mostly inside the texture, some anywhere in the store) and samples.
    task automatic run_texture_phase(input logic [8:0] width, input logic [8:0] height,
                                     input bit wrap, input bit srgb, input int count);
        int                 area;
        logic [15:0]        idx;
        logic signed [23:0] u;
        logic signed [23:0] v;
        settle_block();
        apply_settings(width, height, wrap, srgb);
        fill_texture();
        area = eff_dim(tex_w, TEX_MAX_W) * eff_dim(tex_h, TEX_MAX_H);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if (area > 0 && $urandom_range(0, 9) < 7)
                    idx = 16'($urandom_range(0, area - 1));
                else
                    idx = 16'($urandom);
                send_item(write_item(idx, random_texel()));
            end
            else
            begin
                pick_coords(u, v);
                send_item(sample_item(u, v));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves no texture: every sample returns 1.0 on all channels,
    // and a write lands in the store regardless.
    task automatic test_no_texture();
        send_item(sample_item(24'sh7FFFFF, -24'sd8388608));
        send_item(write_item(16'hFFFF, 32'h12345678));
        send_item(sample_item(24'sd0, 24'sd0));
    endtask

    // Hand-picked texels on a 2 x 2 texture: an exact texel hit, a four-way
    // blend and the coordinate extremes, first clamped with sRGB decode,
    // then wrapped with linear decode.
    task automatic test_small_texture();
        logic signed [23:0] probe_u [4];
        logic signed [23:0] probe_v [4];
        logic [31:0]        texel   [4];
        probe_u = '{24'sh004000, 24'sh008000, 24'sh7FFFFF, -24'sd8388608};
        probe_v = '{24'sh004000, 24'sh008000, -24'sd8388608, 24'sh7FFFFF};
        texel   = '{32'h00000000, 32'hFFFFFFFF, 32'h40800B0A, 32'h017F00FF};
        settle_block();
        apply_settings(9'd2, 9'd2, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++)
            send_item(write_item(16'(k), texel[k]));
        for (int k = 0; k < 4; k++)
            send_item(sample_item(probe_u[k], probe_v[k]));
        settle_block();
        apply_settings(9'd2, 9'd2, 1'b1, 1'b0);
        for (int k = 0; k < 4; k++)
            send_item(sample_item(probe_u[k], probe_v[k]));
    endtask

    // Hold the output off for a long stretch while samples keep coming, so
    // the result register fills and the input stalls.
    task automatic test_backpressure();
        logic signed [23:0] u;
        logic signed [23:0] v;
        settle_block();
        hold_req <= hold_req + 1;
        for (int i = 0; i < 8; i++)
        begin
            pick_coords(u, v);
            send_item(sample_item(u, v));
        end
    endtask

    // Smallest, widest, tallest and largest textures, oversize dimensions
    // that saturate, and a zero in either dimension.
    task automatic test_dimension_extremes();
        run_texture_phase(9'd1,   9'd1,   1'b0, 1'b1, 16);
        run_texture_phase(9'd256, 9'd1,   1'b1, 1'b0, 16);
        run_texture_phase(9'd1,   9'd256, 1'b0, 1'b1, 16);
        run_texture_phase(9'd256, 9'd256, 1'b1, 1'b1, 16);
        run_texture_phase(9'd511, 9'd300, 1'b0, 1'b0, 16);
        run_texture_phase(9'd300, 9'd1,   1'b1, 1'b1, 16);
        run_texture_phase(9'd0,   9'd9,   1'b1, 1'b0, 8);
        run_texture_phase(9'd17,  9'd0,   1'b0, 1'b1, 8);
    endtask

    // Random small textures and modes; the first runs with no idling.
    task automatic test_random_textures();
        for (int p = 0; p < 4; p++)
        begin
            idle_on = (p != 0);
            run_texture_phase(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                              1'($urandom), 1'($urandom), 30);
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls plus the requested hold-off, and a
    // field-by-field check of every accepted result against the oldest
    // prediction
    // ------------------------------------------------------------------
    function automatic string channel_name(int k);
        case (k)
            0:       return "red";
            1:       return "green";
            2:       return "blue";
            default: return "alpha";
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [63:0] data);
        rgba_t want;
        if (expected_colors.size() == 0)
        begin
            report_mismatch($sformatf("result %h arrived with no sample outstanding", data));
        end
        else
        begin
            want = expected_colors.pop_front();
            for (int k = 0; k < 4; k++)
                if (data[16*k +: 16] !== want[k])
                    report_mismatch($sformatf("result %0d %s: got %0d, want %0d", result_count,
                                              channel_name(k), data[16*k +: 16], want[k]));
        end
        result_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= !(idle_on && $urandom_range(0, 99) < 12);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < 256; i++)
            srgb_lut[i] = srgb_entry(i);
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_texture();
        test_small_texture();
        test_backpressure();
        test_dimension_extremes();
        test_random_textures();

        settle_block();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
